/* design/lcs_length_engine_defines.svh */
// Assertion macros shared by the LCS length engine RTL.
`ifndef LCS_LENGTH_ENGINE_DEFINES_SVH
`define LCS_LENGTH_ENGINE_DEFINES_SVH

`ifndef SYNTH
// Checks that cons holds in the same cycle as ante.
`define LCS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcs_length_engine: same-cycle check failed");
// Checks that cons holds in the cycle after ante.
`define LCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcs_length_engine: next-cycle check failed");
`else
`define LCS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* design/lcs_pkg.sv */
// Shared constants and types for the LCS length engine.
package lcs_pkg;

    localparam int LCS_MAX_LEN_DEF     = 256;
    localparam int LCS_SYMBOL_BITS_DEF = 8;

    localparam int LCS_SYM_PORT_W = 8;
    localparam int LCS_LEN_OUT_W  = 9;
    localparam int LCS_LEN_OUT_MAX = 511;

    localparam logic LCS_MODE_FIRST  = 1'b0;
    localparam logic LCS_MODE_SECOND = 1'b1;

    // Control of the two storage arrays, driven by the sequencer.
    typedef struct packed {
        logic sym_we;
        logic row_we;
        logic rd_en;
    } lcs_store_ctl_t;

endpackage

/* design/lcs_if.sv */
// Request and result channel interfaces of the LCS length engine.
interface lcs_sym_if;
    logic                               valid;
    logic                               ready;
    logic                               mode;
    logic [lcs_pkg::LCS_SYM_PORT_W-1:0] symbol;
    logic                               last;

    modport source (output valid, output mode, output symbol, output last, input ready);
    modport sink (input valid, input mode, input symbol, input last, output ready);
endinterface

interface lcs_res_if;
    logic                              valid;
    logic                              ready;
    logic [lcs_pkg::LCS_LEN_OUT_W-1:0] lcs_length;
    logic                              overflow;

    modport source (output valid, output lcs_length, output overflow, input ready);
    modport sink (input valid, input lcs_length, input overflow, output ready);
endinterface

/* design/lcs_length_engine.sv */
// Top level of the LCS length engine: sequencer, output register and checks.
//
//   port     | dir  | carries
//   ---------+------+------------------------------------------
//   symbols  | sink | mode, symbol, last (one symbol per request)
//   result   | src  | lcs_length, overflow (one per string pair)
//
// A first-string symbol is written to the symbol store on acceptance. A
// second-string symbol starts a sweep over the stored first string, one cell
// per cycle through the shared cell unit and the row memory port; no new
// symbol is taken until the sweep ends. The final symbol then loads the result
// register, and stalls there while an earlier result still waits for the
// consumer. Reset clears all control state; the row needs no clearing pass,
// since the first sweep after a new first string reads every cell as zero.
`include "lcs_length_engine_defines.svh"

module lcs_length_engine #(
    parameter int MAX_LEN     = lcs_pkg::LCS_MAX_LEN_DEF,
    parameter int SYMBOL_BITS = lcs_pkg::LCS_SYMBOL_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    lcs_sym_if.sink       symbols,
    lcs_res_if.source     result
);

    localparam int SYM_W = (SYMBOL_BITS < lcs_pkg::LCS_SYM_PORT_W) ?
                           SYMBOL_BITS : lcs_pkg::LCS_SYM_PORT_W;
    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int LEN_W = CNT_W;
    localparam int IDX_W = $clog2(MAX_LEN);
    localparam int OUT_W = lcs_pkg::LCS_LEN_OUT_W;
    localparam int EXT_W = (LEN_W > OUT_W) ? LEN_W : OUT_W;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_DONE  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             overflow_reg, overflow_next;
    logic             loading_reg, loading_next;
    logic             fresh_reg, fresh_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic             pipe_valid_reg, pipe_valid_next;
    logic             out_valid_reg, out_valid_next;

    logic [SYM_W-1:0] sym_reg, sym_next;
    logic             last_reg, last_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [LEN_W-1:0] diag_reg, diag_next;
    logic [LEN_W-1:0] up_reg, up_next;
    logic [OUT_W-1:0] out_len_reg;
    logic             out_ovf_reg;

    lcs_pkg::lcs_store_ctl_t store_ctl;
    logic [IDX_W-1:0] sym_wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic [SYM_W-1:0] sym_rd;
    logic [LEN_W-1:0] row_rd;
    logic [LEN_W-1:0] left;
    logic [LEN_W-1:0] cell_len;
    logic [CNT_W-1:0] count_eff;
    logic             in_acc;
    logic             issue;
    logic             out_load;
    logic [EXT_W-1:0] len_ext;
    logic [OUT_W-1:0] len_sat;

    assign in_acc = symbols.valid && symbols.ready;
    assign symbols.ready = (state_reg == S_IDLE);

    // The first sweep after a new first string sees a cleared row.
    assign left = fresh_reg ? '0 : row_rd;

    lcs_store #(
        .MAX_LEN (MAX_LEN),
        .SYM_W   (SYM_W),
        .LEN_W   (LEN_W)
    ) u_store (
        .clk         (clk),
        .ctl         (store_ctl),
        .sym_wr_addr (sym_wr_addr),
        .sym_wr_data (symbols.symbol[SYM_W-1:0]),
        .row_wr_addr (wr_idx_reg),
        .row_wr_data (cell_len),
        .rd_addr     (rd_addr),
        .sym_rd      (sym_rd),
        .row_rd      (row_rd)
    );

    lcs_cell_unit #(
        .SYM_W (SYM_W),
        .LEN_W (LEN_W)
    ) u_cell (
        .sym_a    (sym_rd),
        .sym_b    (sym_reg),
        .diag     (diag_reg),
        .left     (left),
        .up       (up_reg),
        .cell_len (cell_len)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        overflow_next   = overflow_reg;
        loading_next    = loading_reg;
        fresh_next      = fresh_reg;
        rd_idx_next     = rd_idx_reg;
        pipe_valid_next = 1'b0;
        sym_next        = sym_reg;
        last_next       = last_reg;
        wr_idx_next     = wr_idx_reg;
        diag_next       = diag_reg;
        up_next         = up_reg;
        store_ctl       = '0;
        sym_wr_addr     = '0;
        rd_addr         = rd_idx_reg[IDX_W-1:0];
        issue           = 1'b0;
        out_load        = 1'b0;
        count_eff       = loading_reg ? count_reg : '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc && symbols.mode == lcs_pkg::LCS_MODE_FIRST)
                begin
                    // A first-string symbol after a finished first string
                    // abandons the pair and starts over.
                    loading_next  = 1'b1;
                    overflow_next = loading_reg ? overflow_reg : 1'b0;
                    count_next    = count_eff;
                    if (count_eff < CNT_W'(MAX_LEN))
                    begin
                        store_ctl.sym_we = 1'b1;
                        sym_wr_addr      = count_eff[IDX_W-1:0];
                        count_next       = count_eff + CNT_W'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (symbols.last)
                    begin
                        loading_next = 1'b0;
                        fresh_next   = 1'b1;
                    end
                end
                else if (in_acc && !loading_reg)
                begin
                    sym_next    = symbols.symbol[SYM_W-1:0];
                    last_next   = symbols.last;
                    rd_idx_next = '0;
                    diag_next   = '0;
                    up_next     = '0;
                    state_next  = S_SWEEP;
                end
            end
            S_SWEEP:
            begin
                issue           = (rd_idx_reg < count_reg);
                store_ctl.rd_en = issue;
                pipe_valid_next = issue;
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                    wr_idx_next = rd_idx_reg[IDX_W-1:0];
                end
                if (pipe_valid_reg)
                begin
                    store_ctl.row_we = 1'b1;
                    diag_next        = left;
                    up_next          = cell_len;
                end
                if (!issue && !pipe_valid_reg)
                begin
                    fresh_next = 1'b0;
                    state_next = last_reg ? S_DONE : S_IDLE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load      = 1'b1;
                    state_next    = S_IDLE;
                    count_next    = '0;
                    overflow_next = 1'b0;
                    loading_next  = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // up_reg holds the last cell of the row once the sweep has drained.
    assign len_ext = EXT_W'(up_reg);
    assign len_sat = (len_ext > EXT_W'(lcs_pkg::LCS_LEN_OUT_MAX)) ?
                     OUT_W'(lcs_pkg::LCS_LEN_OUT_MAX) : len_ext[OUT_W-1:0];

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            loading_reg    <= 1'b1;
            fresh_reg      <= 1'b0;
            rd_idx_reg     <= '0;
            pipe_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            overflow_reg   <= overflow_next;
            loading_reg    <= loading_next;
            fresh_reg      <= fresh_next;
            rd_idx_reg     <= rd_idx_next;
            pipe_valid_reg <= pipe_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg    <= sym_next;
        last_reg   <= last_next;
        wr_idx_reg <= wr_idx_next;
        diag_reg   <= diag_next;
        up_reg     <= up_next;
        if (out_load)
        begin
            out_len_reg <= len_sat;
            out_ovf_reg <= overflow_reg;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.lcs_length = out_len_reg;
    assign result.overflow   = out_ovf_reg;

    `LCS_ASSERT_SAME(a_read_in_range, clk, rst_n, store_ctl.rd_en, rd_idx_reg < count_reg)
    `LCS_ASSERT_SAME(a_write_in_range, clk, rst_n, pipe_valid_reg, CNT_W'(wr_idx_reg) < count_reg)
    `LCS_ASSERT_SAME(a_ready_pipe_empty, clk, rst_n, symbols.ready, !pipe_valid_reg)
    `LCS_ASSERT_NEXT(a_load_restarts, clk, rst_n, out_load, loading_reg && count_reg == '0 && out_valid_reg)

endmodule

/* design/lcs_store.sv */
// Storage for the first string and the row of lengths, with registered reads.
module lcs_store #(
    parameter int MAX_LEN = lcs_pkg::LCS_MAX_LEN_DEF,
    parameter int SYM_W   = lcs_pkg::LCS_SYMBOL_BITS_DEF,
    parameter int LEN_W   = 9
) (
    input  logic                           clk,
    input  lcs_pkg::lcs_store_ctl_t        ctl,
    input  logic [$clog2(MAX_LEN)-1:0]     sym_wr_addr,
    input  logic [SYM_W-1:0]               sym_wr_data,
    input  logic [$clog2(MAX_LEN)-1:0]     row_wr_addr,
    input  logic [LEN_W-1:0]               row_wr_data,
    input  logic [$clog2(MAX_LEN)-1:0]     rd_addr,
    output logic [SYM_W-1:0]               sym_rd,
    output logic [LEN_W-1:0]               row_rd
);

    logic [SYM_W-1:0] first_string [MAX_LEN];
    logic [LEN_W-1:0] length_row [MAX_LEN];
    logic [SYM_W-1:0] sym_rd_reg;
    logic [LEN_W-1:0] row_rd_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.sym_we)
        begin
            first_string[sym_wr_addr] <= sym_wr_data;
        end
        if (ctl.rd_en)
        begin
            sym_rd_reg <= first_string[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.row_we)
        begin
            length_row[row_wr_addr] <= row_wr_data;
        end
        if (ctl.rd_en)
        begin
            row_rd_reg <= length_row[rd_addr];
        end
    end

    assign sym_rd = sym_rd_reg;
    assign row_rd = row_rd_reg;

endmodule

/* design/lcs_cell_unit.sv */
// Shared cell update: diagonal plus one on a match, else the larger neighbor.
module lcs_cell_unit #(
    parameter int SYM_W = lcs_pkg::LCS_SYMBOL_BITS_DEF,
    parameter int LEN_W = 9
) (
    input  logic [SYM_W-1:0] sym_a,
    input  logic [SYM_W-1:0] sym_b,
    input  logic [LEN_W-1:0] diag,
    input  logic [LEN_W-1:0] left,
    input  logic [LEN_W-1:0] up,
    output logic [LEN_W-1:0] cell_len
);

    always_comb
    begin
        if (sym_a == sym_b)
        begin
            cell_len = diag + LEN_W'(1);
        end
        else if (left > up)
        begin
            cell_len = left;
        end
        else
        begin
            cell_len = up;
        end
    end

endmodule

/* sim/tb_lcs_length_engine.sv */
// Self-checking testbench for the LCS length engine, using directed and random string pairs.
module tb_lcs_length_engine;

    localparam int MAX_LEN      = lcs_pkg::LCS_MAX_LEN_DEF;
    localparam int SYM_W        = lcs_pkg::LCS_SYM_PORT_W;
    localparam int LEN_W        = lcs_pkg::LCS_LEN_OUT_W;
    localparam int NUM_ITEMS    = 1550;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int DRAIN_CYCLES = 2 * MAX_LEN + 16;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [LEN_W-1:0] lcs_length;
        logic             overflow;
    } lcs_result_t;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_MOSTLY,
        READY_BURSTY
    } ready_style_t;

    // Tracks the stored first string and the length row, and queues the lengths to come.
    class lcs_length_tracker;
        logic [SYM_W-1:0] stored_syms[MAX_LEN];
        logic [LEN_W-1:0] len_row[MAX_LEN];
        int unsigned      kept;
        bit               truncated;
        bit               loading;
        lcs_result_t      expected_lengths[$];
        int unsigned      applied;
        int unsigned      mismatches;

        function new();
            kept       = 0;
            truncated  = 1'b0;
            loading    = 1'b1;
            applied    = 0;
            mismatches = 0;
            foreach (len_row[i])
            begin
                len_row[i]     = '0;
                stored_syms[i] = '0;
            end
        endfunction

        function void restart();
            kept      = 0;
            truncated = 1'b0;
            loading   = 1'b1;
        endfunction

        function void flag(string what, int want, int got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch: %s expected %0d actual %0d", what, want, got);
        endfunction

        function void take_symbol(logic mode, logic [SYM_W-1:0] sym, logic last);
            logic [LEN_W-1:0] diag;
            logic [LEN_W-1:0] up;
            logic [LEN_W-1:0] left;
            logic [LEN_W-1:0] new_len;
            lcs_result_t      res;
            if (mode == lcs_pkg::LCS_MODE_FIRST)
            begin
                // A first-string symbol during the second string abandons the pair.
                if (!loading)
                    restart();
                applied++;
                if (kept < MAX_LEN)
                begin
                    stored_syms[kept] = sym;
                    kept++;
                end
                else
                    truncated = 1'b1;
                if (last)
                begin
                    foreach (len_row[i])
                        len_row[i] = '0;
                    loading = 1'b0;
                end
                return;
            end
            if (loading)
                return;
            applied++;
            diag = '0;
            up   = '0;
            for (int i = 0; i < kept; i++)
            begin
                left       = len_row[i];
                new_len    = (stored_syms[i] == sym) ? diag + 1'b1 : ((left > up) ? left : up);
                diag       = left;
                up         = new_len;
                len_row[i] = new_len;
            end
            if (last)
            begin
                res.lcs_length   = len_row[kept - 1];
                res.overflow     = truncated;
                expected_lengths = {expected_lengths, res};
                restart();
            end
        endfunction

        function void check_length(logic [LEN_W-1:0] len, logic ovf);
            lcs_result_t want;
            if (expected_lengths.size() == 0)
            begin
                flag("result with nothing pending, length", -1, int'(len));
                return;
            end
            want = expected_lengths.pop_front();
            if (want.lcs_length !== len)
                flag("lcs_length", int'(want.lcs_length), int'(len));
            if (want.overflow !== ovf)
                flag("overflow", int'(want.overflow), int'(ovf));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   burst_left;
    int   cycle_count;

    lcs_sym_if sym_ch ();
    lcs_res_if res_ch ();

    lcs_length_tracker tracker = new();

    lcs_length_engine DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .symbols(sym_ch),
        .result (res_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    // Requests are noted before results so that both see the same edge in a fixed order.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sym_ch.valid && sym_ch.ready)
                tracker.take_symbol(sym_ch.mode, sym_ch.symbol, sym_ch.last);
            if (res_ch.valid && res_ch.ready)
                tracker.check_length(res_ch.lcs_length, res_ch.overflow);
        end
    end

    initial
    begin
        ready_style_t style;
        int           style_left;
        int           stall_left;
        res_ch.ready = 1'b0;
        style        = READY_ALWAYS;
        style_left   = 0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (style_left == 0)
            begin
                style      = ready_style_t'($urandom_range(0, 3));
                style_left = $urandom_range(64, 256);
            end
            style_left--;
            case (style)
                READY_ALWAYS: res_ch.ready <= 1'b1;
                READY_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
                READY_MOSTLY: res_ch.ready <= ($urandom_range(0, 9) != 0);
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        res_ch.ready <= 1'b0;
                    end
                    else if ($urandom_range(0, 7) == 0)
                    begin
                        stall_left = $urandom_range(1, 30);
                        res_ch.ready <= 1'b0;
                    end
                    else
                        res_ch.ready <= 1'b1;
                end
            endcase
        end
    end

    task automatic pause_sender(input int n);
        sym_ch.valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // Called at a falling edge; returns at a falling edge after the request is taken, sometimes after a random pause.
    task automatic send_symbol(input logic m, input logic [SYM_W-1:0] s, input logic l);
        sym_ch.valid  <= 1'b1;
        sym_ch.mode   <= m;
        sym_ch.symbol <= s;
        sym_ch.last   <= l;
        @(posedge clk);
        while (!sym_ch.ready)
            @(posedge clk);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            pause_sender(($urandom_range(0, 4) != 0) ? $urandom_range(1, 4) : $urandom_range(5, 40));
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 16);
        end
    endtask

    task automatic send_string(input logic m, input int len, input int base, input int span,
                               input bit closes);
        logic [SYM_W-1:0] sym;
        for (int i = 0; i < len; i++)
        begin
            sym = SYM_W'(base + int'($urandom_range(0, span - 1)));
            send_symbol(m, sym, closes && (i == len - 1));
        end
    endtask

    task automatic drain_results();
        sym_ch.valid <= 1'b0;
        @(negedge clk);
        while (tracker.expected_lengths.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int seq;
        int kind;
        int base;
        int span;
        int len_a;
        int len_b;
        sym_ch.valid  = 1'b0;
        sym_ch.mode   = lcs_pkg::LCS_MODE_FIRST;
        sym_ch.symbol = '0;
        sym_ch.last   = 1'b0;
        rst_n         = 1'b0;
        burst_left    = $urandom_range(1, 16);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Second-string symbols with no first string loaded are ignored.
        send_symbol(lcs_pkg::LCS_MODE_SECOND, 8'hA5, 1'b1);
        send_symbol(lcs_pkg::LCS_MODE_SECOND, 8'h00, 1'b0);
        // Extreme symbol values, crossed order.
        send_symbol(lcs_pkg::LCS_MODE_FIRST, 8'h00, 1'b0);
        send_symbol(lcs_pkg::LCS_MODE_FIRST, 8'hFF, 1'b1);
        send_symbol(lcs_pkg::LCS_MODE_SECOND, 8'hFF, 1'b0);
        send_symbol(lcs_pkg::LCS_MODE_SECOND, 8'h00, 1'b1);
        // One symbol each, matching.
        send_symbol(lcs_pkg::LCS_MODE_FIRST, 8'h55, 1'b1);
        send_symbol(lcs_pkg::LCS_MODE_SECOND, 8'h55, 1'b1);
        // Nothing in common.
        send_symbol(lcs_pkg::LCS_MODE_FIRST, 8'h01, 1'b0);
        send_symbol(lcs_pkg::LCS_MODE_FIRST, 8'h02, 1'b1);
        send_symbol(lcs_pkg::LCS_MODE_SECOND, 8'h03, 1'b1);
        // A new first string cuts a second string short.
        send_symbol(lcs_pkg::LCS_MODE_FIRST, 8'h10, 1'b0);
        send_symbol(lcs_pkg::LCS_MODE_FIRST, 8'h20, 1'b1);
        send_symbol(lcs_pkg::LCS_MODE_SECOND, 8'h10, 1'b0);
        send_symbol(lcs_pkg::LCS_MODE_FIRST, 8'h30, 1'b1);
        send_symbol(lcs_pkg::LCS_MODE_SECOND, 8'h30, 1'b0);
        send_symbol(lcs_pkg::LCS_MODE_SECOND, 8'h30, 1'b1);
        // Identical strings.
        send_symbol(lcs_pkg::LCS_MODE_FIRST, 8'h7E, 1'b0);
        send_symbol(lcs_pkg::LCS_MODE_FIRST, 8'h81, 1'b0);
        send_symbol(lcs_pkg::LCS_MODE_FIRST, 8'h7E, 1'b1);
        send_symbol(lcs_pkg::LCS_MODE_SECOND, 8'h7E, 1'b0);
        send_symbol(lcs_pkg::LCS_MODE_SECOND, 8'h81, 1'b0);
        send_symbol(lcs_pkg::LCS_MODE_SECOND, 8'h7E, 1'b1);
        drain_results();

        for (seq = 0; tracker.applied < NUM_ITEMS; seq++)
        begin
            kind = $urandom_range(0, 99);
            base = $urandom_range(0, 255);
            // A narrow alphabet gives many matches, a full one gives few.
            span = ($urandom_range(0, 2) == 0) ? 256 : $urandom_range(1, 4);
            if (seq == 3)
                len_a = MAX_LEN;
            else if (seq == 7)
                len_a = MAX_LEN + $urandom_range(1, 8);
            else if ($urandom_range(0, 199) == 0)
                len_a = $urandom_range(200, 300);
            else if ($urandom_range(0, 9) == 0)
                len_a = $urandom_range(13, 40);
            else
                len_a = $urandom_range(1, 12);
            len_b = (len_a > 64) ? $urandom_range(1, 4) : $urandom_range(1, 12);
            if (kind >= 80 && kind < 90)
                send_string(lcs_pkg::LCS_MODE_SECOND, $urandom_range(1, 3), base, span,
                            1'($urandom_range(0, 1)));
            send_string(lcs_pkg::LCS_MODE_FIRST, len_a, base, span, 1'b1);
            if (kind >= 90)
                send_string(lcs_pkg::LCS_MODE_SECOND, $urandom_range(1, len_b), base, span, 1'b0);
            else
                send_string(lcs_pkg::LCS_MODE_SECOND, len_b, base, span, 1'b1);
            if (seq % 16 == 15)
                drain_results();
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.expected_lengths.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
